// File: design/bpm_pkg.sv
// Package for the block permission map: payload types, function codes and
// the command/status structs shared by the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpm_pkg;

    localparam int FUNC_W    = 2;
    localparam int ADDR_W    = 16;
    localparam int LEN_W     = 16;
    localparam int PERM_W    = 4;
    localparam int COUNT_W   = 13;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CHANGE = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] base_addr;
        logic [LEN_W-1:0]  length_bytes;
        logic [PERM_W-1:0] cmp_mask;
        logic [PERM_W-1:0] check_value;
        logic [PERM_W-1:0] new_perms;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] blocks_changed;
        logic               rejected;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the input transaction
        logic we;        // write the record at the current block
        logic free_data; // write the free value instead of new_perms
        logic step;      // advance the current block, read ahead
        logic cnt_inc;   // count the record just written
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [FUNC_W-1:0] in_func;
        logic              in_set_bad;
        logic              in_range;
        logic              left_zero;
        logic              last;
        logic              match;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: design/bpm_in_if.sv
// Input channel of the block permission map: valid/ready plus one request.
// Depends on bpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bpm_in_if
    import bpm_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/bpm_out_if.sv
// Output channel of the block permission map: valid/ready plus one result.
// Depends on bpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bpm_out_if
    import bpm_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/bpm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bpm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 512,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/bpm_dp.sv
// Datapath of the block permission map: request registers, block walker,
// record RAM, match compare and result register. Depends on bpm_pkg, bpm_ram.
`timescale 1ns / 1ps
`default_nettype none

module bpm_dp
    import bpm_pkg::*;
#(
    parameter int RECORD_BITS = 4,
    parameter int BLOCK_SHIFT = 3,
    parameter int NUM_BLOCKS  = 512,
    parameter int FREE_RECORD = 15
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_item,
    input  wire t_dp_cmd   i_cmd,
    output t_dp_sts        o_sts,
    output t_out_item      o_result
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int CMP_W = (RECORD_BITS > PERM_W) ? RECORD_BITS : PERM_W;

    localparam logic [ADDR_W-1:0] BLK_END  = ADDR_W'(NUM_BLOCKS);
    localparam logic [ADDR_W-1:0] BLK_LAST = ADDR_W'(NUM_BLOCKS - 1);
    localparam logic [LEN_W-1:0]  OFS_MASK = LEN_W'((1 << BLOCK_SHIFT) - 1);
    localparam logic [RECORD_BITS-1:0] FREE_VAL = RECORD_BITS'(FREE_RECORD);

    logic [ADDR_W-1:0]      r_blk;
    logic [LEN_W-1:0]       r_left;
    logic [PERM_W-1:0]      r_mask;
    logic [PERM_W-1:0]      r_check;
    logic [RECORD_BITS-1:0] r_nv;
    logic [CNT_W-1:0]       r_count;
    logic                   r_rej;
    t_out_item              r_result;

    logic [ADDR_W-1:0]      blk_next;
    logic [IDX_W-1:0]       rd_idx;
    logic [RECORD_BITS-1:0] wr_data;
    logic [RECORD_BITS-1:0] rd_data;
    logic [CMP_W-1:0]       rd_ext;
    logic                   set_bad;

    assign blk_next = r_blk + ADDR_W'(1);
    assign set_bad  = (i_item.length_bytes == '0) ||
                      ((i_item.length_bytes & OFS_MASK) != '0);

    // Reset clears the walker so the power-up clearing pass starts at block 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk <= '0;
        end else if (i_cmd.load) begin
            r_blk <= (i_item.func == FUNC_CLEAR) ? '0 : (i_item.base_addr >> BLOCK_SHIFT);
        end else if (i_cmd.step) begin
            r_blk <= blk_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_left  <= i_item.length_bytes >> BLOCK_SHIFT;
            r_mask  <= i_item.cmp_mask;
            r_check <= i_item.check_value;
            r_nv    <= RECORD_BITS'(i_item.new_perms);
            r_count <= '0;
            r_rej   <= (i_item.func == FUNC_SET) && set_bad;
        end else begin
            if (i_cmd.step) begin
                r_left <= r_left - LEN_W'(1);
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_result.blocks_changed <= COUNT_W'(r_count);
            r_result.rejected       <= r_rej;
        end
    end

    // Read ahead one block while the current one is being rewritten.
    assign rd_idx  = i_cmd.step ? blk_next[IDX_W-1:0] : r_blk[IDX_W-1:0];
    assign wr_data = i_cmd.free_data ? FREE_VAL : r_nv;

    bpm_ram #(
        .WIDTH (RECORD_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.we),
        .i_waddr (r_blk[IDX_W-1:0]),
        .i_wdata (wr_data),
        .i_raddr (rd_idx),
        .o_rdata (rd_data)
    );

    assign rd_ext = CMP_W'(rd_data);

    assign o_sts.in_func    = i_item.func;
    assign o_sts.in_set_bad = set_bad;
    assign o_sts.in_range   = (r_blk < BLK_END);
    assign o_sts.left_zero  = (r_left == '0);
    assign o_sts.last       = (r_blk == BLK_LAST);
    assign o_sts.match      = ((rd_ext[PERM_W-1:0] & r_mask) == r_check);

    assign o_result = r_result;

endmodule

`default_nettype wire

// File: design/bpm_ctrl.sv
// Controller of the block permission map: sequences clearing, set and change
// walks and owns both handshakes. Depends on bpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpm_ctrl
    import bpm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_CLEAR  = 3'd2;
    localparam logic [2:0] S_SET    = 3'd3;
    localparam logic [2:0] S_CHG_RD = 3'd4;
    localparam logic [2:0] S_CHG    = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                o_cmd.we        = 1'b1;
                o_cmd.free_data = 1'b1;
                o_cmd.step      = 1'b1;
                if (i_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_sts.in_func)
                        FUNC_CLEAR:  n_state = S_CLEAR;
                        FUNC_SET:    n_state = i_sts.in_set_bad ? S_FIN : S_SET;
                        FUNC_CHANGE: n_state = S_CHG_RD;
                        default:     n_state = S_FIN;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.we        = 1'b1;
                o_cmd.free_data = 1'b1;
                o_cmd.step      = 1'b1;
                if (i_sts.last) begin
                    n_state = S_FIN;
                end
            end
            S_SET: begin
                if (!i_sts.left_zero && i_sts.in_range) begin
                    o_cmd.we      = 1'b1;
                    o_cmd.step    = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_CHG_RD: begin
                // read of the start block is issued this cycle
                n_state = i_sts.in_range ? S_CHG : S_FIN;
            end
            S_CHG: begin
                if (i_sts.match) begin
                    o_cmd.we      = 1'b1;
                    o_cmd.step    = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: design/block_permission_map_top.sv
// Block permission map. A set rewrites its records up to the table end; a change
// rewrites records while they match, up to the table end, and none if it starts past it;
// a clear frees every record; a rejected set or unused code writes none.
// One operation at a time; the next transaction can be accepted in the same cycle as
// the result is valid, even while that result still waits in the output register.
// Reset starts a clearing pass; no transaction is taken until it ends.
`timescale 1ns / 1ps
`default_nettype none

module block_permission_map_top
    import bpm_pkg::*;
#(
    parameter int RECORD_BITS = 4,
    parameter int BLOCK_SHIFT = 3,
    parameter int NUM_BLOCKS  = 512,
    parameter int FREE_RECORD = 15
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bpm_in_if.sink     i_cmd,
    bpm_out_if.source  o_rsp
);

    t_dp_cmd   cmd;
    t_dp_sts   sts;
    t_out_item result;
    logic      in_ready;
    logic      out_valid;

    bpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bpm_dp #(
        .RECORD_BITS (RECORD_BITS),
        .BLOCK_SHIFT (BLOCK_SHIFT),
        .NUM_BLOCKS  (NUM_BLOCKS),
        .FREE_RECORD (FREE_RECORD)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_cmd.data),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (result)
    );

    assign i_cmd.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign o_rsp.data  = result;

endmodule

`default_nettype wire

// File: design/bpm_checker.sv
// Port-level checks for the block permission map, bound to the top level.
// Depends on bpm_pkg and block_permission_map_top.
`timescale 1ns / 1ps
`default_nettype none

module bpm_checker
    import bpm_pkg::*;
#(
    parameter int NUM_BLOCKS = 512
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [COUNT_W-1:0] i_blocks_changed,
    input wire logic               i_rejected
);

    // clearing pass after reset: nothing taken the cycle after reset
    a_init_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

    // one operation at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready in the cycle after a transaction");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_rejected) |-> (i_blocks_changed == '0))
        else $error("rejected result with nonzero count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_blocks_changed <= COUNT_W'(NUM_BLOCKS)))
        else $error("count exceeds table size");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_blocks_changed) && $stable(i_rejected)))
        else $error("stalled result changed");

endmodule

bind block_permission_map_top bpm_checker #(
    .NUM_BLOCKS (NUM_BLOCKS)
) u_bpm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_cmd.valid),
    .i_in_ready       (i_cmd.ready),
    .i_out_valid      (o_rsp.valid),
    .i_out_ready      (o_rsp.ready),
    .i_blocks_changed (o_rsp.data.blocks_changed),
    .i_rejected       (o_rsp.data.rejected)
);

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for block_permission_map_top: random and directed
// clear/set/change transactions, with a scoreboard class that tracks the record table.
// Depends on bpm_pkg, bpm_in_if, bpm_out_if and the block under test.
`timescale 1ns / 1ps

import bpm_pkg::*;

class perm_tracker #(
    int RECORD_BITS = 4,
    int BLOCK_SHIFT = 3,
    int NUM_BLOCKS  = 512,
    int FREE_RECORD = 15
);
    localparam int OFFSET_MASK = (1 << BLOCK_SHIFT) - 1;

    bit [RECORD_BITS-1:0] records [NUM_BLOCKS];
    t_out_item            pending [$];
    int                   failures;
    int                   checked;

    function new();
        failures = 0;
        checked  = 0;
        wipe();
    endfunction

    function void wipe();
        foreach (records[i]) records[i] = RECORD_BITS'(FREE_RECORD);
    endfunction

    // Called on every accepted request; updates the table, queues the result.
    function void note_request(t_in_item req);
        t_out_item want;
        int        blk;
        int        left;
        int        count;
        want  = '0;
        count = 0;
        blk   = int'(req.base_addr) >> BLOCK_SHIFT;
        case (req.func)
            FUNC_CLEAR: begin
                wipe();
            end
            FUNC_SET: begin
                if (req.length_bytes == '0 || (int'(req.length_bytes) & OFFSET_MASK) != 0) begin
                    want.rejected = 1'b1;
                end else begin
                    // runs past the end of the table are clipped
                    left = int'(req.length_bytes) >> BLOCK_SHIFT;
                    while (left > 0 && blk < NUM_BLOCKS) begin
                        records[blk] = RECORD_BITS'(req.new_perms);
                        count++;
                        blk++;
                        left--;
                    end
                end
            end
            FUNC_CHANGE: begin
                while (blk < NUM_BLOCKS &&
                       (records[blk] & req.cmp_mask) == req.check_value) begin
                    records[blk] = RECORD_BITS'(req.new_perms);
                    count++;
                    blk++;
                end
            end
            default: ;
        endcase
        want.blocks_changed = count[COUNT_W-1:0];
        pending.push_back(want);
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        if (pending.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("result with nothing pending: blocks_changed=%0d rejected=%0b",
                         got.blocks_changed, got.rejected);
            return;
        end
        want = pending.pop_front();
        if (got.blocks_changed !== want.blocks_changed || got.rejected !== want.rejected) begin
            failures++;
            if (failures <= 10)
                $display("result %0d: blocks_changed exp %0d got %0d, rejected exp %0b got %0b",
                         checked, want.blocks_changed, got.blocks_changed,
                         want.rejected, got.rejected);
        end
        checked++;
    endfunction
endclass

module tb_top;

    localparam int RECORD_BITS  = 4;
    localparam int BLOCK_SHIFT  = 3;
    localparam int NUM_BLOCKS   = 512;
    localparam int FREE_RECORD  = 15;
    localparam int BLOCK_BYTES  = 1 << BLOCK_SHIFT;
    localparam int RANDOM_ITEMS = 950;
    localparam int CYCLE_LIMIT  = 2_000_000;
    // longest operation is a full-table walk
    localparam int DRAIN_CYCLES = 2 * NUM_BLOCKS + 8;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;

    bpm_in_if  cmd_if ();
    bpm_out_if rsp_if ();

    block_permission_map_top #(
        .RECORD_BITS (RECORD_BITS),
        .BLOCK_SHIFT (BLOCK_SHIFT),
        .NUM_BLOCKS  (NUM_BLOCKS),
        .FREE_RECORD (FREE_RECORD)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    perm_tracker #(RECORD_BITS, BLOCK_SHIFT, NUM_BLOCKS, FREE_RECORD) tracker;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic t_in_item mk_req(logic [FUNC_W-1:0] func, int base, int len,
                                        int mask, int check, int perms);
        t_in_item req;
        req.func         = func;
        req.base_addr    = ADDR_W'(base);
        req.length_bytes = LEN_W'(len);
        req.cmp_mask     = PERM_W'(mask);
        req.check_value  = PERM_W'(check);
        req.new_perms    = PERM_W'(perms);
        return req;
    endfunction

    // Mostly in-table sets and changes that match their start record, so the
    // walks cover real runs; the rest is clears, unused codes, bad lengths and far addresses.
    function automatic t_in_item random_req();
        t_in_item req;
        int       pick;
        int       blk;
        req  = t_in_item'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) != 0)
            req.base_addr = ADDR_W'($urandom_range(0, NUM_BLOCKS * BLOCK_BYTES - 1));
        blk = int'(req.base_addr) >> BLOCK_SHIFT;
        if (pick < 2) begin
            req.func = FUNC_CLEAR;
        end else if (pick < 4) begin
            req.func = FUNC_UNUSED;
        end else if (pick < 50) begin
            req.func = FUNC_SET;
            pick = $urandom_range(0, 99);
            if (pick < 80)
                req.length_bytes = LEN_W'($urandom_range(1, 32) * BLOCK_BYTES);
            else if (pick < 88)
                req.length_bytes = LEN_W'($urandom) |
                                   LEN_W'(1 << $urandom_range(0, BLOCK_SHIFT - 1));
            else if (pick < 92)
                req.length_bytes = '0;
            else
                req.length_bytes = LEN_W'($urandom) & ~LEN_W'(BLOCK_BYTES - 1);
        end else begin
            req.func = FUNC_CHANGE;
            if (blk < NUM_BLOCKS && $urandom_range(0, 3) != 0)
                req.check_value = PERM_W'(tracker.records[blk]) & req.cmp_mask;
        end
        return req;
    endfunction

    task automatic send_req(input t_in_item req, input int gap);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= req;
        do @(posedge i_clk); while (!cmd_if.ready);
        tracker.note_request(req);
    endtask

    // response side: random stalls, with stretches of full throughput
    initial begin
        int stall;
        bit no_stall;
        no_stall = 1'b0;
        rsp_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 31) == 0) no_stall = !no_stall;
            stall = no_stall ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            tracker.check_result(rsp_if.data);
        end
    end

    initial begin
        t_in_item directed [$];
        int       gap;
        bit       no_gap;
        int       last_base;

        tracker = new();
        no_gap  = 1'b0;
        last_base = (NUM_BLOCKS - 2) * BLOCK_BYTES;
        i_rst_n      <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(mk_req(FUNC_CLEAR, 0, 0, 0, 0, 0));
        // whole table is free, so this walks to the end
        directed.push_back(mk_req(FUNC_CHANGE, 0, 0, 15, 15, 0));
        directed.push_back(mk_req(FUNC_SET, 0, BLOCK_BYTES, 15, 0, 15));
        directed.push_back(mk_req(FUNC_SET, 0, 0, 0, 0, 3));
        directed.push_back(mk_req(FUNC_SET, 16, BLOCK_BYTES - 1, 0, 0, 3));
        directed.push_back(mk_req(FUNC_SET, 16, 16'hFFFF, 0, 0, 3));
        directed.push_back(mk_req(FUNC_SET, 16'hFFFF, 16'hFFF8, 15, 15, 15));
        directed.push_back(mk_req(FUNC_SET, last_base, 4 * BLOCK_BYTES, 0, 0, 5));
        directed.push_back(mk_req(FUNC_CHANGE, last_base, 0, 15, 5, 9));
        // check bit outside the mask never matches
        directed.push_back(mk_req(FUNC_CHANGE, 0, 0, 3, 4, 1));
        directed.push_back(mk_req(FUNC_CHANGE, 16'hFFFF, 16'hFFFF, 0, 0, 1));
        directed.push_back(mk_req(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 15, 15, 15));
        directed.push_back(mk_req(FUNC_SET, 0, 16'hFFF8, 0, 0, 0));
        directed.push_back(mk_req(FUNC_CHANGE, 0, 0, 0, 0, 10));
        directed.push_back(mk_req(FUNC_SET, 10 * BLOCK_BYTES + 7, 5 * BLOCK_BYTES, 0, 0, 3));
        directed.push_back(mk_req(FUNC_CHANGE, 10 * BLOCK_BYTES, 0, 15, 3, 12));
        directed.push_back(mk_req(FUNC_CHANGE, 12 * BLOCK_BYTES, 0, 12, 8, 6));
        directed.push_back(mk_req(FUNC_CLEAR, 16'hFFFF, 16'hFFFF, 15, 15, 15));

        foreach (directed[i]) send_req(directed[i], $urandom_range(0, 3));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 31) == 0) no_gap = !no_gap;
            gap = no_gap ? 0 : $urandom_range(0, 15);
            send_req(random_req(), gap);
        end
        cmd_if.valid <= 1'b0;

        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
